// ----- hdl/fbsg_pkg.sv -----
package fbsg_pkg;

  localparam int unsigned QuotW = 32;
  localparam int unsigned SpcW  = 8;
  localparam int unsigned RootW = 22;  // entries*32 + bps-1 fits in 22 bits
  localparam int unsigned BpsW  = 16;

  typedef struct packed {
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] sector_count_short;
    logic [31:0] sector_count_long;
    logic [7:0]  fat_copies;
    logic [15:0] reserved_sectors;
    logic [15:0] root_entries;
    logic [15:0] table_sectors_short;
    logic [31:0] table_sectors_long;
    logic [31:0] root_cluster_field;
  } fbsg_in_t;

  typedef struct packed {
    logic        volume_kind;
    logic [31:0] total_sectors;
    logic [31:0] table_size;
    logic [31:0] root_sector;
    logic [31:0] data_start;
    logic [23:0] root_bytes;
    logic [31:0] root_first_cluster;
    logic [31:0] cluster_total;
    logic        divide_fault;
  } fbsg_out_t;

  // sideband carried through the divider chains
  typedef struct packed {
    logic        valid;
    logic        volume_kind;
    logic [31:0] total_sectors;
    logic [31:0] table_size;
    logic [31:0] root_sector;
    logic [23:0] root_bytes;
    logic [31:0] root_first_cluster;
    logic        fault;
  } fbsg_side_t;

endpackage

// ----- hdl/fbsg_if.sv -----
interface fbsg_in_if;
  logic valid;
  logic ready;
  fbsg_pkg::fbsg_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fbsg_out_if;
  logic valid;
  logic ready;
  fbsg_pkg::fbsg_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/fat_boot_sector_geometry_unit.sv -----
// FAT boot sector geometry: one boot sector per cycle in, one layout per cycle
// out while the output is free or taken. The stages: one input stage for the
// products and sums, a 22-cell chain dividing the root
// size by bytes per sector, one add stage, a 32-cell chain dividing the data
// sectors by sectors per cluster, then the output register. The whole pipeline
// advances when the output is free or taken; zero divisors flag divide_fault.
module fat_boot_sector_geometry_unit (
  input logic clk,
  input logic rst_n,
  fbsg_in_if.sink    in_ch,
  fbsg_out_if.source out_ch
);
  import fbsg_pkg::*;

  localparam int unsigned SideW = $bits(fbsg_side_t);

  logic       en;
  fbsg_in_t   d;
  fbsg_side_t s0_nxt, s0_r, s1_w, s2_r, s3_w;
  logic [RootW-1:0] rnum_nxt, rnum_r, rq_w;
  logic [BpsW-1:0]  bps_r;
  logic [31:0] dbase_nxt, dbase_r, dbase1_w, dbase2_r, dbase3_w;
  logic [SpcW-1:0] spc_r, spc1_w, spc2_r;
  logic [31:0] cnum2_r, cq_w, dstart2_nxt;
  logic spc0_w;
  logic bps1_zero;
  logic [RootW-1:0] bz_r;
  logic out_valid_r;
  fbsg_out_t out_r;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign d = in_ch.data;

  always_comb begin
    logic [31:0] total, prod;
    total = (d.sector_count_short != '0) ? {16'h0, d.sector_count_short}
                                          : d.sector_count_long;
    s0_nxt = '0;
    s0_nxt.valid = in_ch.valid;
    s0_nxt.total_sectors = total;
    rnum_nxt = '0;
    if (d.root_entries != '0) begin
      prod = 32'(d.fat_copies) * 32'(d.table_sectors_short);
      s0_nxt.volume_kind = 1'b0;
      s0_nxt.table_size = {16'h0, d.table_sectors_short};
      s0_nxt.root_sector = 32'(d.reserved_sectors) + prod;
      s0_nxt.root_bytes = {3'b0, d.root_entries, 5'b0};
      s0_nxt.fault = (d.bytes_per_sector == '0) || (d.sectors_per_cluster == '0);
      rnum_nxt = RootW'({d.root_entries, 5'b0}) + RootW'(d.bytes_per_sector)
                 - RootW'(d.bytes_per_sector != '0);
      dbase_nxt = s0_nxt.root_sector;
    end else begin
      prod = 32'(d.fat_copies) * d.table_sectors_long;
      s0_nxt.volume_kind = 1'b1;
      s0_nxt.table_size = d.table_sectors_long;
      s0_nxt.root_bytes = 24'(d.sectors_per_cluster) * 24'(d.bytes_per_sector);
      s0_nxt.root_first_cluster = d.root_cluster_field;
      s0_nxt.fault = d.sectors_per_cluster == '0;
      dbase_nxt = 32'(d.reserved_sectors) + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.valid <= 1'b0;
    else if (en) s0_r.valid <= s0_nxt.valid;
    if (en) begin
      s0_r[SideW-2:0] <= s0_nxt[SideW-2:0];
      rnum_r  <= rnum_nxt;
      bps_r   <= (s0_nxt.volume_kind) ? '0 : d.bytes_per_sector;
      dbase_r <= dbase_nxt;
      spc_r   <= d.sectors_per_cluster;
    end
  end

  // quotient from a zero divisor is meaningless; bypassed below
  fbsg_div_chain #(.NumW(RootW), .DenW(BpsW), .SideW(SideW + 32 + SpcW)) u_rdiv (
    .clk(clk), .rst_n(rst_n), .en(en), .num_i(rnum_r), .den_i(bps_r),
    .side_i({s0_r, dbase_r, spc_r}),
    .quo_o(rq_w), .side_o({s1_w, dbase1_w, spc1_w})
  );

  // bytes-per-sector zero seen at the end of the root chain
  always_ff @(posedge clk) begin
    if (en) bz_r <= {bz_r[RootW-2:0], bps_r == '0};
  end
  assign bps1_zero = bz_r[RootW-1];

  always_comb begin
    if (s1_w.volume_kind || bps1_zero) dstart2_nxt = dbase1_w;
    else dstart2_nxt = dbase1_w + 32'(rq_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_r.valid <= 1'b0;
    else if (en) s2_r.valid <= s1_w.valid;
    if (en) begin
      s2_r[SideW-2:0] <= s1_w[SideW-2:0];
      dbase2_r <= dstart2_nxt;
      cnum2_r  <= s1_w.total_sectors - dstart2_nxt;
      spc2_r   <= spc1_w;
    end
  end

  fbsg_div_chain #(.NumW(QuotW), .DenW(SpcW), .SideW(SideW + 33)) u_cdiv (
    .clk(clk), .rst_n(rst_n), .en(en), .num_i(cnum2_r), .den_i(spc2_r),
    .side_i({s2_r, dbase2_r, spc2_r == '0}),
    .quo_o(cq_w), .side_o({s3_w, dbase3_w, spc0_w})
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= s3_w.valid;
    if (en) begin
      out_r.volume_kind        <= s3_w.volume_kind;
      out_r.total_sectors      <= s3_w.total_sectors;
      out_r.table_size         <= s3_w.table_size;
      out_r.root_sector        <= s3_w.root_sector;
      out_r.data_start         <= dbase3_w;
      out_r.root_bytes         <= s3_w.root_bytes;
      out_r.root_first_cluster <= s3_w.root_first_cluster;
      out_r.cluster_total      <= spc0_w ? '0 : cq_w;
      out_r.divide_fault       <= s3_w.fault;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_r))
    else $error("result changed while stalled");
  a_fat32_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.volume_kind |-> out_r.root_sector == '0)
    else $error("FAT32 root sector nonzero");
  a_fat16_clu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.volume_kind |-> out_r.root_first_cluster == '0)
    else $error("FAT16 root cluster nonzero");
endmodule

// ----- hdl/fbsg_div_cell.sv -----
// One restoring quotient bit: shifts in the next dividend bit.
module fbsg_div_cell #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DenW-1:0] den_i,
  input  logic [DenW-1:0] rem_i,
  input  logic [NumW-1:0] num_i,
  output logic [DenW-1:0] den_o,
  output logic [DenW-1:0] rem_o,
  output logic [NumW-1:0] num_o
);
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic [DenW-1:0] rem_nxt;
  logic [NumW-1:0] num_nxt;
  logic [DenW-1:0] rem_r;
  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;

  always_comb begin
    trial = {rem_i, num_i[NumW-1]};
    diff  = trial - {1'b0, den_i};
    if (!diff[DenW]) begin
      rem_nxt = diff[DenW-1:0];
      num_nxt = {num_i[NumW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DenW-1:0];
      num_nxt = {num_i[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign den_o = den_r;
endmodule

// ----- hdl/fbsg_div_chain.sv -----
// Row of divider cells, one quotient bit per cell, with sideband riding along.
module fbsg_div_chain #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 8,
  parameter int unsigned SideW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);
  logic [DenW-1:0]  den_w  [NumW+1];
  logic [DenW-1:0]  rem_w  [NumW+1];
  logic [NumW-1:0]  num_w  [NumW+1];
  logic [SideW-1:0] side_r [NumW];

  assign den_w[0] = den_i;
  assign rem_w[0] = '0;
  assign num_w[0] = num_i;

  for (genvar i = 0; i < NumW; i++) begin : g_cell
    fbsg_div_cell #(.NumW(NumW), .DenW(DenW)) u_cell (
      .clk(clk), .en(en),
      .den_i(den_w[i]), .rem_i(rem_w[i]), .num_i(num_w[i]),
      .den_o(den_w[i+1]), .rem_o(rem_w[i+1]), .num_o(num_w[i+1])
    );
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) side_r[0] <= '0;
        else if (en) side_r[0] <= side_i;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (!rst_n) side_r[i] <= '0;
        else if (en) side_r[i] <= side_r[i-1];
      end
    end
  end

  assign quo_o  = num_w[NumW];
  assign side_o = side_r[NumW-1];
endmodule

// ----- sim/tb_if_note.sv -----
module tb_clock_gen (
  output logic clk
);
  timeunit 1ns;
  timeprecision 1ps;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end
endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbsg_pkg::*;

  localparam int Latency   = 57;
  localparam int WatchLimit = 4000;
  localparam int NumRandom = 600;

  logic clk;
  logic rst_n;
  int   errors = 0;
  int   idle_cycles = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;

  fbsg_in_if  in_ch();
  fbsg_out_if out_ch();

  tb_clock_gen clkgen (.clk(clk));

  fat_boot_sector_geometry_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  typedef struct {
    fbsg_in_t  fields;
    bit        has_golden;
    fbsg_out_t golden;
  } sector_row_t;

  fbsg_out_t layout_queue[$];
  sector_row_t directed_rows[$];

  function automatic fbsg_out_t compute_layout(fbsg_in_t b);
    fbsg_out_t   r;
    logic [31:0] bps, spc, rbytes32;
    bps = {16'd0, b.bytes_per_sector};
    spc = {24'd0, b.sectors_per_cluster};
    r = '0;
    r.total_sectors = (b.sector_count_short != 0) ? {16'd0, b.sector_count_short}
                                                  : b.sector_count_long;
    if (b.root_entries != 0) begin
      r.volume_kind = 1'b0;
      r.table_size = {16'd0, b.table_sectors_short};
      r.root_sector = 32'(b.reserved_sectors) + 32'(b.fat_copies) * r.table_size;
      rbytes32 = 32'(b.root_entries) * 32'd32;
      r.root_bytes = rbytes32[23:0];
      if (bps == 0) begin
        r.divide_fault = 1'b1;
        r.data_start = r.root_sector;
      end else begin
        r.data_start = r.root_sector + (rbytes32 + (bps - 32'd1)) / bps;
      end
    end else begin
      r.volume_kind = 1'b1;
      r.table_size = b.table_sectors_long;
      r.data_start = 32'(b.reserved_sectors) + r.table_size * 32'(b.fat_copies);
      rbytes32 = spc * bps;
      r.root_bytes = rbytes32[23:0];
      r.root_first_cluster = b.root_cluster_field;
    end
    if (spc == 0) begin
      r.divide_fault = 1'b1;
    end else begin
      r.cluster_total = (r.total_sectors - r.data_start) / spc;
    end
    return r;
  endfunction

  function automatic fbsg_in_t random_sector();
    fbsg_in_t b;
    b.bytes_per_sector    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                            : 16'(32'd512 << $urandom_range(0, 3));
    if ($urandom_range(0, 30) == 0) b.bytes_per_sector = '0;
    b.sectors_per_cluster = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                            : 8'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 30) == 0) b.sectors_per_cluster = '0;
    b.sector_count_short  = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
    b.sector_count_long   = $urandom;
    b.fat_copies          = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                            : 8'($urandom_range(1, 2));
    b.reserved_sectors    = 16'($urandom);
    b.root_entries        = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
    b.table_sectors_short = 16'($urandom);
    b.table_sectors_long  = ($urandom_range(0, 1) == 0) ? $urandom
                            : $urandom_range(0, 65535);
    b.root_cluster_field  = $urandom;
    return b;
  endfunction

  task automatic add_row(fbsg_in_t f, bit known, fbsg_out_t g);
    sector_row_t row;
    row.fields = f;
    row.has_golden = known;
    row.golden = g;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    fbsg_in_t  f;
    fbsg_out_t g;
    // all zero: FAT32, both divisors zero
    f = '0;
    g = '0;
    g.volume_kind = 1'b1;
    g.divide_fault = 1'b1;
    add_row(f, 1'b1, g);
    // all ones: FAT16 via root_entries
    f = '1;
    add_row(f, 1'b0, g);
    // typical FAT16
    f = '0;
    f.bytes_per_sector = 16'd512; f.sectors_per_cluster = 8'd4;
    f.sector_count_short = 16'd20000; f.fat_copies = 8'd2;
    f.reserved_sectors = 16'd1; f.root_entries = 16'd512;
    f.table_sectors_short = 16'd20;
    g = '0;
    g.total_sectors = 32'd20000; g.table_size = 32'd20; g.root_sector = 32'd41;
    g.data_start = 32'd73; g.root_bytes = 24'd16384;
    g.cluster_total = (32'd20000 - 32'd73) / 32'd4;
    add_row(f, 1'b1, g);
    // FAT16 with zero bytes per sector
    f.bytes_per_sector = '0;
    g.data_start = 32'd41; g.cluster_total = (32'd20000 - 32'd41) / 32'd4;
    g.divide_fault = 1'b1;
    add_row(f, 1'b1, g);
    // FAT16 zero sectors per cluster
    f.bytes_per_sector = 16'd512; f.sectors_per_cluster = '0;
    add_row(f, 1'b0, g);
    // FAT32 typical, long count, zero bps is no fault
    f = '0;
    f.sectors_per_cluster = 8'd8; f.sector_count_long = 32'd1000000;
    f.fat_copies = 8'd2; f.reserved_sectors = 16'd32;
    f.table_sectors_long = 32'd1000; f.root_cluster_field = 32'd2;
    g = '0;
    g.volume_kind = 1'b1; g.total_sectors = 32'd1000000; g.table_size = 32'd1000;
    g.data_start = 32'd2032; g.root_first_cluster = 32'd2;
    g.cluster_total = (32'd1000000 - 32'd2032) / 32'd8;
    add_row(f, 1'b1, g);
    // data area beyond total: wrapping subtraction
    f.sector_count_long = 32'd10;
    add_row(f, 1'b0, g);
    // overflowing products
    f.table_sectors_long = 32'hFFFF_FFFF; f.fat_copies = 8'hFF;
    f.bytes_per_sector = 16'hFFFF; f.sectors_per_cluster = 8'hFF;
    add_row(f, 1'b0, g);
    // short count wins over long
    f.sector_count_short = 16'hFFFF; f.sector_count_long = 32'hFFFF_FFFF;
    add_row(f, 1'b0, g);
    // max root entries with tiny and odd sector sizes
    f = '0;
    f.root_entries = 16'hFFFF; f.sectors_per_cluster = 8'd1;
    f.bytes_per_sector = 16'd1; f.sector_count_long = 32'hFFFF_FFFF;
    add_row(f, 1'b0, g);
    f.bytes_per_sector = 16'd3; f.root_entries = 16'd1;
    add_row(f, 1'b0, g);
    f.bytes_per_sector = 16'hFFFF; f.table_sectors_short = 16'hFFFF;
    f.fat_copies = 8'hFF; f.reserved_sectors = 16'hFFFF;
    add_row(f, 1'b0, g);
    f = '1; f.root_entries = '0;
    add_row(f, 1'b0, g);
  endtask

  // sender: drives one transfer and waits for acceptance
  task automatic send_sector(fbsg_in_t b);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    layout_queue.push_back(compute_layout(b));
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // golden rows must agree with the predictor too
  initial begin
    build_directed();
    foreach (directed_rows[i])
      if (directed_rows[i].has_golden
          && compute_layout(directed_rows[i].fields) !== directed_rows[i].golden) begin
        $error("directed row %0d: predictor disagrees with typed expectation", i);
        errors++;
      end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) send_sector(directed_rows[i].fields);
    for (int n = 0; n < NumRandom; n++) begin
      case (n)
        100: begin src_idle_pct = 48; snk_stall_pct = 0; end
        200: begin src_idle_pct = 0;  snk_stall_pct = 48; end
        300: begin src_idle_pct = 30; snk_stall_pct = 30; end
        400: begin src_idle_pct = 0;  snk_stall_pct = 0; hold_off = 1'b1; end
        500: begin src_idle_pct = 30; snk_stall_pct = 30; end
        default: ;
      endcase
      send_sector(random_sector());
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver ready, with one long hold-off to back the pipe up
  initial begin
    int hold_cnt;
    @(posedge rst_n);
    wait (hold_off);
    hold_cnt = 0;
    while (hold_cnt < 200) begin
      @(posedge clk);
      hold_cnt++;
    end
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      out_ch.ready <= !hold_off &&
                      !(snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    fbsg_out_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (layout_queue.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = layout_queue.pop_front();
        check_field("volume_kind", 32'(want.volume_kind), 32'(got.volume_kind));
        check_field("total_sectors", want.total_sectors, got.total_sectors);
        check_field("table_size", want.table_size, got.table_size);
        check_field("root_sector", want.root_sector, got.root_sector);
        check_field("data_start", want.data_start, got.data_start);
        check_field("root_bytes", 32'(want.root_bytes), 32'(got.root_bytes));
        check_field("root_first_cluster", want.root_first_cluster,
                    got.root_first_cluster);
        check_field("cluster_total", want.cluster_total, got.cluster_total);
        check_field("divide_fault", 32'(want.divide_fault), 32'(got.divide_fault));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (layout_queue.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0 && layout_queue.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
